[rtl/core/text_console_char_writer_defines.svh]
// ----------------------------------------------------------------
// Text console writer assertion macros
// Shared concurrent assertion forms for the console writer.
// ----------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define TCW_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcw: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcw: next-cycle check failed");

`endif

[rtl/core/tcw_pkg.sv]
// ----------------------------------------------------------------
// Text console writer package
// Geometry, field widths, character codes and control structs.
// ----------------------------------------------------------------
package tcw_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;

   // item field widths
   localparam int CMD_W     = 2;
   localparam int CHAR_W    = 8;
   localparam int INDEX_W   = 11;
   localparam int WORD_W    = 16;
   localparam int OUT_COL_W = 7;
   localparam int OUT_ROW_W = 5;

   // derived widths
   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int CNT_W  = $clog2(CELL_COUNT + 1);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int CMP_W  = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

   // cell and character constants
   localparam logic [WORD_W-1:0] BLANK_CELL   = 16'h0720;
   localparam logic [WORD_W-1:0] ATTR_MASK    = 16'hFF00;
   localparam logic [CHAR_W-1:0] CH_NULL      = 8'd0;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

   // controller to datapath
   typedef struct packed {
      logic accept;       // latch item, issue cell read
      logic exec;         // apply item to cursor and screen
      logic clear_sweep;  // blank characters, keep attributes
      logic init_sweep;   // fill screen with blank cells
      logic load_rsp;     // load result register
   } tcw_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic wrap_clear;   // put ran past the last row
      logic sweep_done;   // sweep counter reached the end
   } tcw_status_type;

endpackage

[rtl/core/tcw_if.sv]
// ----------------------------------------------------------------
// Text console writer channels
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------
interface tcw_req_if;
   logic                        valid;
   logic                        ready;
   logic [tcw_pkg::CMD_W-1:0]   command;
   logic [tcw_pkg::CHAR_W-1:0]  char_code;
   logic [tcw_pkg::INDEX_W-1:0] cell_index;
   logic [tcw_pkg::WORD_W-1:0]  cell_word;

   modport source (output valid, command, char_code, cell_index, cell_word, input ready);
   modport sink   (input valid, command, char_code, cell_index, cell_word, output ready);
endinterface

interface tcw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::WORD_W-1:0]    read_word;
   logic [tcw_pkg::OUT_COL_W-1:0] cursor_column;
   logic [tcw_pkg::OUT_ROW_W-1:0] cursor_row;

   modport source (output valid, read_word, cursor_column, cursor_row, input ready);
   modport sink   (input valid, read_word, cursor_column, cursor_row, output ready);
endinterface

[rtl/core/tcw_ctrl.sv]
// ----------------------------------------------------------------
// Text console writer controller
// Sequences init fill, item execution, screen clear and result.
// ----------------------------------------------------------------
module tcw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  tcw_pkg::tcw_status_type status,
   output tcw_pkg::tcw_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_INIT  = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_EXEC  = 5'b00100,
      ST_CLEAR = 5'b01000,
      ST_RESP  = 5'b10000
   } tcw_state_type;

   tcw_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.init_sweep = 1'b1;
            if (status.sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.wrap_clear) begin
               state_in = ST_CLEAR;
            end else if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_CLEAR: begin
            cmd.clear_sweep = 1'b1;
            if (status.sweep_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/tcw_datapath.sv]
// ----------------------------------------------------------------
// Text console writer datapath
// Screen memory, cursor, sweep counter and result register.
// ----------------------------------------------------------------
module tcw_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  tcw_pkg::tcw_cmd_type          cmd,
   output tcw_pkg::tcw_status_type       status,
   input  logic [tcw_pkg::CMD_W-1:0]     req_command,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::INDEX_W-1:0]   req_cell_index,
   input  logic [tcw_pkg::WORD_W-1:0]    req_cell_word,
   output logic [tcw_pkg::WORD_W-1:0]    rsp_read_word,
   output logic [tcw_pkg::OUT_COL_W-1:0] rsp_cursor_column,
   output logic [tcw_pkg::OUT_ROW_W-1:0] rsp_cursor_row
);

   localparam int AW   = tcw_pkg::ADDR_W;
   localparam int CW   = tcw_pkg::CNT_W;
   localparam int XW   = tcw_pkg::CMP_W;
   localparam int COLW = tcw_pkg::COL_W;
   localparam int ROWW = tcw_pkg::ROW_W;
   localparam int WW   = tcw_pkg::WORD_W;
   localparam int OCW  = tcw_pkg::OUT_COL_W;
   localparam int ORW  = tcw_pkg::OUT_ROW_W;

   // screen memory
   logic [WW-1:0] screen_ff [tcw_pkg::CELL_COUNT];
   logic [WW-1:0] rdata_ff;

   // cursor and sweep counter
   logic [COLW-1:0] col_ff, col_in;
   logic [ROWW-1:0] row_ff, row_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   // latched item
   logic [tcw_pkg::CMD_W-1:0]  cmd_ff;
   logic [tcw_pkg::CHAR_W-1:0] char_ff;
   logic [WW-1:0]              word_ff;
   logic [AW-1:0]              addr_ff, addr_in;
   logic                       idx_ok_ff, idx_ok_in;

   // result
   logic [WW-1:0]  hold_word_ff;
   logic [WW-1:0]  rsp_word_ff, rsp_word_in;
   logic [OCW-1:0] rsp_col_ff, rsp_col_in;
   logic [ORW-1:0] rsp_row_ff, rsp_row_in;

   logic [AW-1:0]     cur_addr, rd_addr, wr_addr, ex_addr;
   logic [XW-1:0]     idx_wide;
   logic [CW-1:0]     cnt_dec;
   logic              wr_en, ex_wr;
   logic [WW-1:0]     wr_data, ex_data, rd_word;
   logic [COLW:0]     col_next;
   logic [ROWW:0]     row_next;
   logic              wrap;
   logic [OCW+COLW-1:0] col_out;
   logic [ORW+ROWW-1:0] row_out;

   // cursor cell address, row-major
   assign cur_addr = AW'(row_ff) * AW'(tcw_pkg::COLUMNS) + AW'(col_ff);
   assign idx_wide = XW'(req_cell_index);
   assign idx_ok_in = idx_wide < XW'(tcw_pkg::CELL_COUNT);
   assign cnt_dec  = cnt_ff - CW'(1);

   // read address at accept: backspace looks at the cell to the left
   always_comb begin
      if (req_command == tcw_pkg::CMD_PUT) begin
         addr_in = (req_char_code == tcw_pkg::CH_BACKSPACE) ? cur_addr - AW'(1) : cur_addr;
      end else begin
         addr_in = idx_wide[AW-1:0];
      end
   end

   assign rd_addr = cmd.clear_sweep ? cnt_ff[AW-1:0] : addr_in;

   // item execution
   always_comb begin
      col_next = {1'b0, col_ff};
      row_next = {1'b0, row_ff};
      ex_wr    = 1'b0;
      ex_addr  = addr_ff;
      ex_data  = word_ff;
      rd_word  = '0;
      wrap     = 1'b0;
      unique case (cmd_ff)
         tcw_pkg::CMD_PUT: begin
            if (char_ff == tcw_pkg::CH_NULL) begin
               ex_wr = 1'b0;
            end else if (char_ff == tcw_pkg::CH_NEWLINE) begin
               col_next = '0;
               row_next = row_next + (ROWW+1)'(1);
            end else if (char_ff == tcw_pkg::CH_BACKSPACE) begin
               if (col_ff != '0) begin
                  col_next = col_next - (COLW+1)'(1);
                  ex_wr    = 1'b1;
                  ex_data  = (rdata_ff & tcw_pkg::ATTR_MASK) | WW'(tcw_pkg::CH_SPACE);
               end
            end else begin
               ex_wr    = 1'b1;
               ex_data  = (rdata_ff & tcw_pkg::ATTR_MASK) | WW'(char_ff);
               col_next = col_next + (COLW+1)'(1);
            end
            if (col_next >= (COLW+1)'(tcw_pkg::COLUMNS)) begin
               col_next = '0;
               row_next = row_next + (ROWW+1)'(1);
            end
            if (row_next >= (ROWW+1)'(tcw_pkg::ROWS)) begin
               wrap     = 1'b1;
               col_next = '0;
               row_next = '0;
            end
         end
         tcw_pkg::CMD_READ: begin
            rd_word = idx_ok_ff ? rdata_ff : '0;
         end
         tcw_pkg::CMD_WRITE: begin
            ex_wr = idx_ok_ff;
         end
         default: begin
            ex_wr = 1'b0;
         end
      endcase
   end

   // write port select
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ex_addr;
      wr_data = ex_data;
      if (cmd.init_sweep) begin
         wr_en   = cnt_ff < CW'(tcw_pkg::CELL_COUNT);
         wr_addr = cnt_ff[AW-1:0];
         wr_data = tcw_pkg::BLANK_CELL;
      end else if (cmd.clear_sweep) begin
         // write trails the read by one cell
         wr_en   = cnt_ff != '0;
         wr_addr = cnt_dec[AW-1:0];
         wr_data = (rdata_ff & tcw_pkg::ATTR_MASK) | WW'(tcw_pkg::CH_SPACE);
      end else if (cmd.exec) begin
         wr_en = ex_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         screen_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= screen_ff[rd_addr];
   end

   assign status.wrap_clear = cmd.exec && wrap;
   assign status.sweep_done = cnt_ff == CW'(tcw_pkg::CELL_COUNT);

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.init_sweep || cmd.clear_sweep) begin
         cnt_in = status.sweep_done ? '0 : cnt_ff + CW'(1);
      end
      col_in = cmd.exec ? col_next[COLW-1:0] : col_ff;
      row_in = cmd.exec ? row_next[ROWW-1:0] : row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         cnt_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff    <= req_command;
         char_ff   <= req_char_code;
         word_ff   <= req_cell_word;
         addr_ff   <= addr_in;
         idx_ok_ff <= idx_ok_in;
      end
      if (cmd.exec) begin
         hold_word_ff <= rd_word;
      end
   end

   // result source: live values in the execute cycle, held ones later
   always_comb begin
      rsp_word_in = cmd.exec ? rd_word : hold_word_ff;
      col_out     = {{OCW{1'b0}}, col_in};
      row_out     = {{ORW{1'b0}}, row_in};
      rsp_col_in  = col_out[OCW-1:0];
      rsp_row_in  = row_out[ORW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_word_ff <= rsp_word_in;
         rsp_col_ff  <= rsp_col_in;
         rsp_row_ff  <= rsp_row_in;
      end
   end

   assign rsp_read_word     = rsp_word_ff;
   assign rsp_cursor_column = rsp_col_ff;
   assign rsp_cursor_row    = rsp_row_ff;

endmodule

[rtl/core/text_console_char_writer.sv]
// ----------------------------------------------------------------
// Text console character writer
// Screen cell store with cursor, put-character and cell access.
// ----------------------------------------------------------------
// After reset the block fills all COLUMNS*ROWS screen cells with 0x0720, one
// cell a cycle, and takes no item until that is done. Each accepted item is
// first latched while the addressed cell is read from the screen RAM
// (registered read); then the cursor is modified and the cell written back.
// The result sits in an output register, so a new item is accepted while the
// previous one waits to be taken. A put that runs past the last row blanks
// every character (attributes kept) by a read-modify-write sweep over the
// single write port before its result is loaded.
// ----------------------------------------------------------------
`include "text_console_char_writer_defines.svh"

module text_console_char_writer (
   input  logic       clock,
   input  logic       reset,
   tcw_req_if.sink    req_ch,
   tcw_rsp_if.source  rsp_ch
);

   tcw_pkg::tcw_cmd_type    cmd;
   tcw_pkg::tcw_status_type status;

   // sequencing: init fill, accept, execute, clear sweep, result
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // screen RAM, cursor and result payload
   tcw_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_command       (req_ch.command),
      .req_char_code     (req_ch.char_code),
      .req_cell_index    (req_ch.cell_index),
      .req_cell_word     (req_ch.cell_word),
      .rsp_read_word     (rsp_ch.read_word),
      .rsp_cursor_column (rsp_ch.cursor_column),
      .rsp_cursor_row    (rsp_ch.cursor_row)
   );

   // one item in flight: no accept right after an accept
   `TCW_ASSERT_NEXT(a_one_item, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)

   // controller phases never overlap
   `TCW_ASSERT_NOW(a_phase_excl, clock, reset, 1'b1,
                   $onehot0({cmd.accept, cmd.exec, cmd.clear_sweep, cmd.init_sweep}))

   // a result is loaded only into a free output register
   `TCW_ASSERT_NOW(a_rsp_slot, clock, reset, cmd.load_rsp, !rsp_ch.valid || rsp_ch.ready)

   // running past the last row starts the clear sweep next cycle
   `TCW_ASSERT_NEXT(a_wrap_clear, clock, reset, status.wrap_clear, cmd.clear_sweep)

endmodule

[dv/text_console_char_writer_tb.sv]
// ----------------------------------------------------------------
// Text console character writer testbench
// Drives put, read, write and unused commands into the console engine
// through randomly stalled valid/ready channels. A shadow screen and
// cursor in the bench predict every result, which is checked field by
// field in order of arrival.
// ----------------------------------------------------------------
module text_console_char_writer_tb;
   import tcw_pkg::*;

   // command 3 has no name in the package; the block must treat it as a no-op
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int HOLD_CYCLES   = 300;        // long receiver hold-off
   localparam int DRAIN_CYCLES  = 16;         // settle time after the last result
   localparam int RANDOM_ITEMS  = 950;        // useful random items to send
   localparam int RUN_LIMIT     = 8_000_000;  // timeout, time units

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [CHAR_W-1:0]  char_code;
      logic [INDEX_W-1:0] cell_index;
      logic [WORD_W-1:0]  cell_word;
   } req_item_t;

   typedef struct packed {
      logic [WORD_W-1:0]    read_word;
      logic [OUT_COL_W-1:0] cursor_column;
      logic [OUT_ROW_W-1:0] cursor_row;
   } rsp_item_t;

   // one row of the opening sequence; typed=1 means the result is given here
   typedef struct packed {
      logic [CMD_W-1:0]     command;
      logic [CHAR_W-1:0]    char_code;
      logic [INDEX_W-1:0]   cell_index;
      logic [WORD_W-1:0]    cell_word;
      logic                 typed;
      logic [WORD_W-1:0]    read_word;
      logic [OUT_COL_W-1:0] cursor_column;
      logic [OUT_ROW_W-1:0] cursor_row;
   } step_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tcw_req_if req_ch ();
   tcw_rsp_if rsp_ch ();

   text_console_char_writer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------
   // Shadow console: screen cells and cursor, updated at each accepted item
   // ---------------------------------------------------------------
   logic [WORD_W-1:0] cell_shadow [CELL_COUNT];
   int unsigned       cursor_col_m;
   int unsigned       cursor_row_m;

   rsp_item_t pending_rsp [$];   // results still owed by the block, oldest first

   // run statistics
   int unsigned n_items, n_puts, n_reads, n_writes, n_other, n_clears;
   int unsigned n_results, n_errors, n_useful;

   // sender runs without gaps while set; receiver hold-off handshake flags
   bit burst_mode;
   bit hold_ask, hold_done;

   int unsigned ready_on, ready_off;

   // overwrite the character byte of one cell, attribute stays
   function automatic void shadow_set_char(int unsigned idx, logic [CHAR_W-1:0] ch);
      if (idx < CELL_COUNT) begin
         cell_shadow[idx] = {cell_shadow[idx][WORD_W-1:CHAR_W], ch};
      end
   endfunction

   function automatic rsp_item_t console_predict(req_item_t it);
      rsp_item_t   r;
      int unsigned idx;
      r   = '0;
      idx = it.cell_index;
      case (it.command)
         CMD_PUT: begin
            if (it.char_code != CH_NULL) begin
               if (it.char_code == CH_NEWLINE) begin
                  cursor_col_m = 0;
                  cursor_row_m++;
               end else if (it.char_code == CH_BACKSPACE) begin
                  // no effect at column 0
                  if (cursor_col_m > 0) begin
                     cursor_col_m--;
                     shadow_set_char(cursor_row_m * COLUMNS + cursor_col_m, CH_SPACE);
                  end
               end else begin
                  shadow_set_char(cursor_row_m * COLUMNS + cursor_col_m, it.char_code);
                  cursor_col_m++;
               end
               if (cursor_col_m >= COLUMNS) begin
                  cursor_col_m = 0;
                  cursor_row_m++;
               end
               // ran past the last row: blank all characters, keep attributes, home
               if (cursor_row_m >= ROWS) begin
                  for (int unsigned i = 0; i < CELL_COUNT; i++) begin
                     shadow_set_char(i, CH_SPACE);
                  end
                  cursor_col_m = 0;
                  cursor_row_m = 0;
                  n_clears++;
               end
            end
         end
         CMD_READ: begin
            if (idx < CELL_COUNT) begin
               r.read_word = cell_shadow[idx];
            end
         end
         CMD_WRITE: begin
            // out-of-range write is dropped
            if (idx < CELL_COUNT) begin
               cell_shadow[idx] = it.cell_word;
            end
         end
         default: ;
      endcase
      r.cursor_column = OUT_COL_W'(cursor_col_m);
      r.cursor_row    = OUT_ROW_W'(cursor_row_m);
      return r;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int unsigned gap_len(bit quiet);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 65) begin
         return 0;
      end else if (roll < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // ---------------------------------------------------------------
   // Sender: offer one item after a random gap, hold it until accepted.
   // Inputs move on the falling edge; acceptance is seen on the rising edge.
   // valid is never lowered and raised in one step: the gap loop and the
   // final drive each sit on a falling edge of their own.
   // ---------------------------------------------------------------
   task automatic offer_item(input req_item_t it, input rsp_item_t typed_rsp,
                             input bit use_typed);
      rsp_item_t predicted;
      int unsigned gap;
      gap = gap_len(burst_mode);
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid      <= 1'b1;
      req_ch.command    <= it.command;
      req_ch.char_code  <= it.char_code;
      req_ch.cell_index <= it.cell_index;
      req_ch.cell_word  <= it.cell_word;
      do @(posedge clock); while (!req_ch.ready);
      // accepted at this edge; the shadow always advances, even for typed rows
      predicted = console_predict(it);
      pending_rsp.push_back(use_typed ? typed_rsp : predicted);
      n_items++;
      case (it.command)
         CMD_PUT:   n_puts++;
         CMD_READ:  n_reads++;
         CMD_WRITE: n_writes++;
         default:   n_other++;
      endcase
      // items the block just ignores do not count toward the random budget
      if (!(it.command == CMD_UNUSED ||
            (it.command == CMD_PUT && it.char_code == CH_NULL) ||
            (it.command == CMD_WRITE && it.cell_index >= CELL_COUNT))) begin
         n_useful++;
      end
   endtask

   task automatic issue(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                        input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] word);
      req_item_t it;
      it = '{cmd, ch, idx, word};
      offer_item(it, '0, 1'b0);
   endtask

   // random cell address, now and then past the end of the screen
   function automatic logic [INDEX_W-1:0] pick_index();
      if ($urandom_range(0, 7) == 0) begin
         return INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
      end
      return INDEX_W'($urandom_range(0, CELL_COUNT - 1));
   endfunction

   // byte 11..255 most of the time, any byte (null, newline, backspace too) sometimes
   function automatic logic [CHAR_W-1:0] pick_char();
      if ($urandom_range(0, 9) == 0) begin
         return CHAR_W'($urandom_range(0, 255));
      end
      return CHAR_W'($urandom_range(11, 255));
   endfunction

   // ---------------------------------------------------------------
   // Opening sequence. Rows with typed=1 come straight from the reset
   // picture (blank cells 0x0720, cursor home) and the error cases.
   // ---------------------------------------------------------------
   step_row_t opening_steps [25] = '{
      // reset contents, first and last cell
      '{CMD_READ,   CH_NULL,      11'd0,    16'h0000, 1'b1, BLANK_CELL, 7'd0, 5'd0},
      '{CMD_READ,   CH_NULL,      11'd1999, 16'h0000, 1'b1, BLANK_CELL, 7'd0, 5'd0},
      // reads past the end of the screen return zero
      '{CMD_READ,   CH_NULL,      11'd2047, 16'h0000, 1'b1, 16'h0000,   7'd0, 5'd0},
      '{CMD_READ,   CH_NULL,      11'd2000, 16'h0000, 1'b1, 16'h0000,   7'd0, 5'd0},
      // unused command with every field at its top value
      '{CMD_UNUSED, 8'hFF,        11'h7FF,  16'hFFFF, 1'b1, 16'h0000,   7'd0, 5'd0},
      // null character changes nothing
      '{CMD_PUT,    CH_NULL,      11'h7FF,  16'hFFFF, 1'b1, 16'h0000,   7'd0, 5'd0},
      // backspace at column 0 is a no-op
      '{CMD_PUT,    CH_BACKSPACE, 11'd0,    16'h0000, 1'b1, 16'h0000,   7'd0, 5'd0},
      // top byte value, attribute kept
      '{CMD_PUT,    8'hFF,        11'h7FF,  16'hFFFF, 1'b1, 16'h0000,   7'd1, 5'd0},
      '{CMD_READ,   CH_NULL,      11'd0,    16'h0000, 1'b1, 16'h07FF,   7'd1, 5'd0},
      // the rest is checked against the shadow console
      '{CMD_PUT,    8'h01,        11'd0,    16'h0000, 1'b0, 16'h0000,   7'd0, 5'd0},
      '{CMD_PUT,    CH_BACKSPACE, 11'd0,    16'h0000, 1'b0, 16'h0000,   7'd0, 5'd0},
      '{CMD_READ,   CH_NULL,      11'd1,    16'h0000, 1'b0, 16'h0000,   7'd0, 5'd0},
      '{CMD_WRITE,  CH_NULL,      11'd2000, 16'hFFFF, 1'b0, 16'h0000,   7'd0, 5'd0},
      '{CMD_WRITE,  CH_NULL,      11'd2047, 16'hFFFF, 1'b0, 16'h0000,   7'd0, 5'd0},
      '{CMD_WRITE,  CH_NULL,      11'd1999, 16'hABCD, 1'b0, 16'h0000,   7'd0, 5'd0},
      '{CMD_READ,   CH_NULL,      11'd1999, 16'h0000, 1'b0, 16'h0000,   7'd0, 5'd0},
      '{CMD_WRITE,  CH_NULL,      11'd0,    16'h0000, 1'b0, 16'h0000,   7'd0, 5'd0},
      '{CMD_READ,   CH_NULL,      11'd0,    16'h0000, 1'b0, 16'h0000,   7'd0, 5'd0},
      '{CMD_PUT,    CH_NEWLINE,   11'd0,    16'h0000, 1'b0, 16'h0000,   7'd0, 5'd0},
      // colored cell at the new cursor, then a put must keep the attribute
      '{CMD_WRITE,  CH_NULL,      11'd80,   16'h1E00, 1'b0, 16'h0000,   7'd0, 5'd0},
      '{CMD_PUT,    8'h41,        11'd0,    16'h0000, 1'b0, 16'h0000,   7'd0, 5'd0},
      '{CMD_READ,   CH_NULL,      11'd80,   16'h0000, 1'b0, 16'h0000,   7'd0, 5'd0},
      '{CMD_PUT,    CH_SPACE,     11'd0,    16'h0000, 1'b0, 16'h0000,   7'd0, 5'd0},
      '{CMD_PUT,    8'h7F,        11'd0,    16'h0000, 1'b0, 16'h0000,   7'd0, 5'd0},
      '{CMD_READ,   CH_NULL,      11'd2047, 16'h0000, 1'b0, 16'h0000,   7'd0, 5'd0}
   };

   // ---------------------------------------------------------------
   // Receiver: ready bursts with random holes, long open stretches, and one
   // long hold-off while the sender keeps pushing so the block backs up.
   // ---------------------------------------------------------------
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         if (hold_ask && !hold_done) begin
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_ch.ready <= 1'b0;
            end
            hold_done = 1'b1;
         end else begin
            ready_on = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 20);
            repeat (ready_on) begin
               @(negedge clock);
               rsp_ch.ready <= 1'b1;
            end
            ready_off = gap_len(1'b0);
            repeat (ready_off) begin
               @(negedge clock);
               rsp_ch.ready <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Result checker: each accepted result against the oldest prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin : check_results
      rsp_item_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_results++;
         if (pending_rsp.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected result read_word %h column %0d row %0d",
                     $time, rsp_ch.read_word, rsp_ch.cursor_column, rsp_ch.cursor_row);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_ch.read_word !== want.read_word) begin
               n_errors++;
               $display("%0t: read_word expected %h got %h",
                        $time, want.read_word, rsp_ch.read_word);
            end
            if (rsp_ch.cursor_column !== want.cursor_column) begin
               n_errors++;
               $display("%0t: cursor_column expected %0d got %0d",
                        $time, want.cursor_column, rsp_ch.cursor_column);
            end
            if (rsp_ch.cursor_row !== want.cursor_row) begin
               n_errors++;
               $display("%0t: cursor_row expected %0d got %0d",
                        $time, want.cursor_row, rsp_ch.cursor_row);
            end
         end
      end
   end

   // hard stop; covers a block that hangs in its clear or never responds
   initial begin
      #RUN_LIMIT;
      $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin : main_seq
      req_item_t   it;
      rsp_item_t   typed_rsp;
      int unsigned len;
      int unsigned at;
      req_ch.valid      = 1'b0;
      req_ch.command    = CMD_PUT;
      req_ch.char_code  = CH_NULL;
      req_ch.cell_index = '0;
      req_ch.cell_word  = '0;
      for (int unsigned i = 0; i < CELL_COUNT; i++) begin
         cell_shadow[i] = BLANK_CELL;
      end
      cursor_col_m = 0;
      cursor_row_m = 0;

      // synchronous reset first; the block then fills the screen
      // on its own and holds ready low until done
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (opening_steps[k]) begin
         it        = '{opening_steps[k].command, opening_steps[k].char_code,
                       opening_steps[k].cell_index, opening_steps[k].cell_word};
         typed_rsp = '{opening_steps[k].read_word, opening_steps[k].cursor_column,
                       opening_steps[k].cursor_row};
         offer_item(it, typed_rsp, opening_steps[k].typed);
      end

      // receiver goes quiet for a while as the random part starts
      hold_ask = 1'b1;
      n_useful = 0;

      // random part: episodes of well-formed text with random content, plus noise
      while (n_useful < RANDOM_ITEMS) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               // a run of text, long enough at times to wrap the column
               len = $urandom_range(1, 100);
               repeat (len) issue(CMD_PUT, pick_char(), pick_index(),
                                  WORD_W'($urandom_range(0, 16'hFFFF)));
            end
            3: begin
               // newline burst, pushes toward the last row and the clear
               len = $urandom_range(1, 30);
               repeat (len) issue(CMD_PUT, CH_NEWLINE, '0, '0);
            end
            4: begin
               len = $urandom_range(1, 12);
               repeat (len) issue(CMD_PUT, CH_BACKSPACE, '0, '0);
            end
            5: begin
               // color the cursor cell, print over it, read it back
               at = cursor_row_m * COLUMNS + cursor_col_m;
               issue(CMD_WRITE, CH_NULL, INDEX_W'(at), WORD_W'($urandom_range(0, 16'hFFFF)));
               issue(CMD_PUT, CHAR_W'($urandom_range(11, 255)), '0, '0);
               issue(CMD_READ, CH_NULL, INDEX_W'(at), '0);
            end
            6: begin
               len = $urandom_range(1, 10);
               repeat (len) issue(CMD_READ, CH_NULL, pick_index(), '0);
            end
            7: begin
               len = $urandom_range(1, 10);
               repeat (len) issue(CMD_WRITE, CH_NULL, pick_index(),
                                  WORD_W'($urandom_range(0, 16'hFFFF)));
            end
            8: begin
               // ignored items: unused command, null put, write off the screen
               case ($urandom_range(0, 2))
                  0: issue(CMD_UNUSED, CHAR_W'($urandom_range(0, 255)),
                           INDEX_W'($urandom_range(0, 2047)),
                           WORD_W'($urandom_range(0, 16'hFFFF)));
                  1: issue(CMD_PUT, CH_NULL, INDEX_W'($urandom_range(0, 2047)), '0);
                  default: issue(CMD_WRITE, CH_NULL,
                                 INDEX_W'($urandom_range(CELL_COUNT, 2047)),
                                 WORD_W'($urandom_range(0, 16'hFFFF)));
               endcase
            end
            default: begin
               // fully random items
               len = $urandom_range(1, 20);
               repeat (len) issue(CMD_W'($urandom_range(0, 3)),
                                  CHAR_W'($urandom_range(0, 255)),
                                  INDEX_W'($urandom_range(0, 2047)),
                                  WORD_W'($urandom_range(0, 16'hFFFF)));
            end
         endcase
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;

      // every item gives one result; wait for the last, then let things settle
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d items: %0d puts, %0d reads, %0d writes, %0d unused",
               n_items, n_puts, n_reads, n_writes, n_other);
      $display("%0d screen clears, %0d results checked, %0d mismatches",
               n_clears, n_results, n_errors);
      if (n_errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
